[hdl/assert_macros.svh]
// Assertion helpers; every check is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property.
`define GREM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define GREM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/grem_pkg.sv]
`timescale 1ns / 1ps
package grem_pkg;

  localparam int unsigned GR_W      = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned POS_W     = 27;
  localparam int unsigned MINC_W    = 15;
  localparam int unsigned FLOOR_W   = 15;
  localparam int unsigned RATE_W    = 19;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned PROD_W    = TIME_W + RATE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd2;

  localparam logic [MINC_W-1:0]  MIN_COMP_RST    = 15'd128;
  localparam logic [FLOOR_W-1:0] REL_FLOOR_RST   = 15'd256;
  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 19'd48000;

  // round half up before dropping the fraction bits
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (FRAC_W - 1);

  // three position conversions, issued one a cycle, each through the time read, product and position registers
  localparam logic [2:0] POS_ISSUES = 3'd3;
  localparam logic [2:0] POS_LAST   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_POS,
    ST_EMIT
  } grem_state_t;

  typedef enum logic [1:0] {
    SEL_ATTACK_START  = 2'd0,
    SEL_ATTACK_END    = 2'd1,
    SEL_RELEASE_START = 2'd2
  } grem_pos_sel_t;

  typedef struct packed {
    logic          load;
    logic          scan_init;
    logic          scan_en;
    logic          pos_issue;
    grem_pos_sel_t pos_sel;
    logic          emit;
  } grem_cmd_t;

  typedef struct packed {
    logic comp_ok;
    logic scan_done;
    logic out_free;
  } grem_sts_t;

endpackage

[hdl/grem_in_if.sv]
`timescale 1ns / 1ps
interface grem_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [grem_pkg::GR_W-1:0]  gr_db;
  logic [grem_pkg::TIME_W-1:0]       point_time;
  logic                              last_point;

  modport source (output valid, output gr_db, output point_time, output last_point,
                  input ready);
  modport sink   (input valid, input gr_db, input point_time, input last_point,
                  output ready);
endinterface

[hdl/grem_out_if.sv]
`timescale 1ns / 1ps
interface grem_out_if;
  logic                         valid;
  logic                         ready;
  logic [grem_pkg::POS_W-1:0]   attack_start;
  logic [grem_pkg::POS_W-1:0]   attack_end;
  logic [grem_pkg::POS_W-1:0]   release_start;
  logic                         compression_found;

  modport source (output valid, output attack_start, output attack_end,
                  output release_start, output compression_found, input ready);
  modport sink   (input valid, input attack_start, input attack_end,
                  input release_start, input compression_found, output ready);
endinterface

[hdl/gain_reduction_event_markers.sv]
`timescale 1ns / 1ps
// channel   dir  handshake          beat payload
// in_ch     in   valid/ready        gr_db, point_time, last_point
// out_ch    out  valid/ready        attack_start, attack_end, release_start,
//                                   compression_found
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// A point is taken while the controller is idle. A last point then goes through a
// decide step and, if compression is found, a scan through the single read port
// of the reduction store and three shared-multiplier position conversions; the
// result register is then loaded.
// Synchronous active-low reset clears control, counters and config; the stores
// are not cleared. Plain points are taken while a result waits on out_ch; a
// last point holds in the result stage until the output register frees up.
module gain_reduction_event_markers #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  grem_in_if.sink                         in_ch,
  grem_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [grem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grem_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  grem_pkg::grem_cmd_t cmd;
  grem_pkg::grem_sts_t sts;
  logic                in_rdy;

  grem_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_ch.valid),
    .in_last_i  (in_ch.last_point),
    .in_ready_o (in_rdy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  grem_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_gr_db              (in_ch.gr_db),
    .in_point_time         (in_ch.point_time),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_attack_start      (out_ch.attack_start),
    .out_attack_end        (out_ch.attack_end),
    .out_release_start     (out_ch.release_start),
    .out_compression_found (out_ch.compression_found)
  );

  assign in_ch.ready = in_rdy;

endmodule

[hdl/grem_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grem_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  grem_pkg::grem_sts_t sts_i,
  output grem_pkg::grem_cmd_t cmd_o
);

  grem_pkg::grem_state_t state_r, state_nxt;
  logic [2:0]            pos_cnt_r, pos_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= grem_pkg::ST_IDLE;
      pos_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pos_cnt_r <= pos_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pos_cnt_nxt = '0;
    unique case (state_r)
      grem_pkg::ST_IDLE: begin
        if (in_valid_i && in_last_i) state_nxt = grem_pkg::ST_DECIDE;
      end
      grem_pkg::ST_DECIDE: begin
        state_nxt = sts_i.comp_ok ? grem_pkg::ST_SCAN : grem_pkg::ST_EMIT;
      end
      grem_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_nxt = grem_pkg::ST_POS;
      end
      grem_pkg::ST_POS: begin
        if (pos_cnt_r == grem_pkg::POS_LAST) begin
          state_nxt = grem_pkg::ST_EMIT;
        end else begin
          pos_cnt_nxt = pos_cnt_r + 3'd1;
        end
      end
      grem_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_nxt = grem_pkg::ST_IDLE;
      end
      default: state_nxt = grem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.pos_sel   = grem_pkg::grem_pos_sel_t'(pos_cnt_r[1:0]);
    unique case (state_r)
      grem_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      grem_pkg::ST_DECIDE: cmd_o.scan_init = 1'b1;
      grem_pkg::ST_SCAN:   cmd_o.scan_en   = 1'b1;
      grem_pkg::ST_POS:    cmd_o.pos_issue = (pos_cnt_r < grem_pkg::POS_ISSUES);
      grem_pkg::ST_EMIT:   cmd_o.emit      = sts_i.out_free;
      default: ;
    endcase
  end

  `GREM_ASSERT_IMPL(a_pos_cnt_idle, state_r != grem_pkg::ST_POS, pos_cnt_r == 3'd0, "conversion counter running outside POS")
  `GREM_ASSERT(a_last_starts_decide, (state_r == grem_pkg::ST_IDLE && in_valid_i && in_last_i) |=> (state_r == grem_pkg::ST_DECIDE), "last beat did not start evaluation")

endmodule

[hdl/grem_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module grem_dp #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [grem_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [grem_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic signed [grem_pkg::GR_W-1:0]       in_gr_db,
  input  logic [grem_pkg::TIME_W-1:0]            in_point_time,
  input  grem_pkg::grem_cmd_t                    cmd_i,
  output grem_pkg::grem_sts_t                    sts_o,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [grem_pkg::POS_W-1:0]             out_attack_start,
  output logic [grem_pkg::POS_W-1:0]             out_attack_end,
  output logic [grem_pkg::POS_W-1:0]             out_release_start,
  output logic                                   out_compression_found
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned GW = grem_pkg::GR_W;
  localparam int unsigned PW = grem_pkg::PROD_W;
  localparam int unsigned QW = grem_pkg::POS_W;

  // configuration
  logic [grem_pkg::MINC_W-1:0]  min_comp_r;
  logic [grem_pkg::FLOOR_W-1:0] floor_r;
  logic [grem_pkg::RATE_W-1:0]  rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_comp_r <= grem_pkg::MIN_COMP_RST;
      floor_r    <= grem_pkg::REL_FLOOR_RST;
      rate_r     <= grem_pkg::SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grem_pkg::CFG_MIN_COMP:    min_comp_r <= cfg_wdata[grem_pkg::MINC_W-1:0];
        grem_pkg::CFG_REL_FLOOR:   floor_r    <= cfg_wdata[grem_pkg::FLOOR_W-1:0];
        grem_pkg::CFG_SAMPLE_RATE: rate_r     <= cfg_wdata[grem_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // timeline stores
  logic [GW-1:0]                   gr_mem   [DEPTH];
  logic [grem_pkg::TIME_W-1:0]     time_mem [DEPTH];

  logic [CW-1:0]        count_r;
  logic signed [GW-1:0] peak_r;
  logic [IW-1:0]        peak_idx_r;
  logic                 wr_en;

  assign wr_en = cmd_i.load && (count_r < CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gr_mem[count_r[IW-1:0]]   <= in_gr_db;
      time_mem[count_r[IW-1:0]] <= in_point_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      peak_r     <= '0;
      peak_idx_r <= '0;
    end else if (cmd_i.emit) begin
      count_r    <= '0;
      peak_r     <= '0;
      peak_idx_r <= '0;
    end else if (wr_en) begin
      if (count_r == '0 || in_gr_db > peak_r) begin
        peak_r     <= in_gr_db;
        peak_idx_r <= count_r[IW-1:0];
      end
      count_r <= count_r + CW'(1);
    end
  end

  // crossing scan, one stored point a cycle
  logic [CW-1:0]        scan_addr_r;
  logic                 rd_vld_r;
  logic [CW-1:0]        rd_idx_r;
  logic signed [GW-1:0] rd_gr_r;
  logic signed [GW-1:0] prev_r;
  logic                 a_found_r, r_found_r;
  logic [IW-1:0]        a_idx_r, r_idx_r;
  logic                 eval, att_hit, rel_hit;
  logic signed [GW:0]   gr_x2, peak_x;

  always_ff @(posedge clk) begin
    rd_gr_r <= gr_mem[scan_addr_r[IW-1:0]];
  end

  assign gr_x2   = {rd_gr_r, 1'b0};
  assign peak_x  = {peak_r[GW-1], peak_r};
  assign eval    = cmd_i.scan_en && rd_vld_r;
  assign att_hit = eval && !a_found_r && (rd_idx_r != '0) && (gr_x2 >= peak_x)
                   && (rd_gr_r > prev_r);
  assign rel_hit = eval && !r_found_r && (rd_idx_r > CW'(peak_idx_r))
                   && (rd_gr_r <= $signed({1'b0, floor_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      a_found_r   <= 1'b0;
      r_found_r   <= 1'b0;
    end else if (cmd_i.scan_init) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      a_found_r   <= 1'b0;
      r_found_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd_i.scan_en;
      if (cmd_i.scan_en) scan_addr_r <= scan_addr_r + CW'(1);
      if (att_hit) a_found_r <= 1'b1;
      if (rel_hit) r_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.scan_init) begin
      a_idx_r <= '0;
      r_idx_r <= '0;
    end else begin
      if (att_hit) a_idx_r <= rd_idx_r[IW-1:0];
      if (rel_hit) r_idx_r <= rd_idx_r[IW-1:0];
    end
    if (cmd_i.scan_en) rd_idx_r <= scan_addr_r;
    if (eval) prev_r <= rd_gr_r;
  end

  // index -> sample position: read time, multiply by rate, round
  logic [IW-1:0]                  t_addr;
  logic [grem_pkg::TIME_W-1:0]    t_rd_r;
  logic                           s1_vld_r, s2_vld_r;
  grem_pkg::grem_pos_sel_t        s1_sel_r, s2_sel_r;
  logic [PW-1:0]                  prod_r;
  logic [PW-1:0]                  prod_rnd;
  logic [QW-1:0]                  ast_pos_r, aend_pos_r, rel_pos_r;

  always_comb begin
    case (cmd_i.pos_sel)
      grem_pkg::SEL_ATTACK_START:  t_addr = a_idx_r;
      grem_pkg::SEL_RELEASE_START: t_addr = r_idx_r;
      default:                     t_addr = peak_idx_r;
    endcase
  end

  assign prod_rnd = prod_r + grem_pkg::ROUND_ADD;

  always_ff @(posedge clk) begin
    t_rd_r   <= time_mem[t_addr];
    s1_sel_r <= cmd_i.pos_sel;
    prod_r   <= PW'(t_rd_r) * PW'(rate_r);
    s2_sel_r <= s1_sel_r;
    if (s2_vld_r) begin
      case (s2_sel_r)
        grem_pkg::SEL_ATTACK_START:  ast_pos_r  <= prod_rnd[PW-1 -: QW];
        grem_pkg::SEL_ATTACK_END:    aend_pos_r <= prod_rnd[PW-1 -: QW];
        grem_pkg::SEL_RELEASE_START: rel_pos_r  <= prod_rnd[PW-1 -: QW];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd_i.pos_issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // output register
  logic          out_vld_r;
  logic [QW-1:0] out_ast_r, out_aend_r, out_rel_r;
  logic          out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_found_r <= sts_o.comp_ok;
      out_ast_r   <= sts_o.comp_ok ? ast_pos_r : '0;
      out_aend_r  <= sts_o.comp_ok ? aend_pos_r : '0;
      out_rel_r   <= (sts_o.comp_ok && r_found_r) ? rel_pos_r : '0;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_attack_start      = out_ast_r;
  assign out_attack_end        = out_aend_r;
  assign out_release_start     = out_rel_r;
  assign out_compression_found = out_found_r;

  assign sts_o.comp_ok   = (peak_r >= $signed({1'b0, min_comp_r}));
  assign sts_o.scan_done = rd_vld_r && (rd_idx_r == count_r - CW'(1));
  assign sts_o.out_free  = !out_vld_r || out_ready;

  `GREM_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "point count beyond store depth")
  `GREM_ASSERT_IMPL(a_peak_in_range, count_r != '0, CW'(peak_idx_r) < count_r, "peak index outside loaded points")
  `GREM_ASSERT(a_emit_clears, cmd_i.emit |=> (count_r == '0 && peak_r == '0), "timeline not cleared after result")
  `GREM_ASSERT(a_valid_from_emit, $rose(out_vld_r) |-> $past(cmd_i.emit), "result raised without emit")

endmodule
